@@ rtl/cstf_pkg.sv @@
// ----------------------------------------------------------------------------
// cstf_pkg
// Shared types and constants for the callsign token finder.
// ----------------------------------------------------------------------------
package cstf_pkg;

    // Longest token that is stored and can match.
    localparam int TOKEN_MAX = 7;
    // The token length counter stops at this value.
    localparam int LEN_SAT   = 8;
    localparam int LEN_W     = 4;
    localparam int CHAR_W    = 8;

    // ASCII codes that bound the character classes.
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [LEN_W-1:0]  tok_len_t;

    // Element 0 sits in the top byte, so the packed buffer is the result word.
    typedef logic [0:TOKEN_MAX-1][CHAR_W-1:0] tok_buf_t;

    // One input item.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_of_text;
    } cstf_in_t;

    // One result item.
    typedef struct packed {
        logic        found;
        logic [55:0] callsign_chars;
        logic [2:0]  callsign_length;
    } cstf_out_t;

    // Classification of one folded character.
    typedef struct packed {
        char_t ch;
        logic  is_letter;
        logic  is_digit;
        logic  is_alnum;
    } char_info_t;

endpackage

@@ rtl/cstf_char_fold.sv @@
// ----------------------------------------------------------------------------
// cstf_char_fold
// Folds a raw byte to upper case and classifies it as letter or digit.
// ----------------------------------------------------------------------------
module cstf_char_fold (
    input  logic [7:0]           raw_byte,
    output cstf_pkg::char_info_t info
);
    import cstf_pkg::*;

    logic is_lower;

    // Lower-case letters move down to the upper-case range.
    always_comb begin
        is_lower       = (raw_byte >= CHAR_LOWER_A) && (raw_byte <= CHAR_LOWER_Z);
        info.ch        = is_lower ? (raw_byte - CASE_OFFSET) : raw_byte;
        info.is_letter = (info.ch >= CHAR_UPPER_A) && (info.ch <= CHAR_UPPER_Z);
        info.is_digit  = (info.ch >= CHAR_ZERO) && (info.ch <= CHAR_NINE);
        info.is_alnum  = info.is_letter || info.is_digit;
    end

endmodule

@@ rtl/cstf_token_check.sv @@
// ----------------------------------------------------------------------------
// cstf_token_check
// Decides whether a finished token has the callsign shape: one to three
// characters, a digit, then one to three letters, seven characters at most.
// ----------------------------------------------------------------------------
module cstf_token_check (
    input  cstf_pkg::tok_buf_t tok_buf,
    input  cstf_pkg::tok_len_t tok_len,
    output logic               is_match
);
    import cstf_pkg::*;

    logic [TOKEN_MAX-1:0] pos_letter;
    logic [TOKEN_MAX-1:0] pos_digit;
    logic                 shape_ok;

    // Class flags for every stored position.
    always_comb begin
        for (int i = 0; i < TOKEN_MAX; i++) begin
            pos_letter[i] = (tok_buf[i] >= CHAR_UPPER_A) && (tok_buf[i] <= CHAR_UPPER_Z);
            pos_digit[i]  = (tok_buf[i] >= CHAR_ZERO) && (tok_buf[i] <= CHAR_NINE);
        end
    end

    // Try every legal length and letter-run length; all indexes are constant.
    // A digit right before the run makes the run exactly that long.
    always_comb begin
        is_match = 1'b0;
        shape_ok = 1'b0;
        for (int l = 3; l <= TOKEN_MAX; l++) begin
            for (int k = 1; k <= 3; k++) begin
                if ((l - 1 - k >= 1) && (l - 1 - k <= 3)) begin
                    shape_ok = (tok_len == LEN_W'(l)) && pos_digit[l - 1 - k];
                    for (int j = l - k; j < l; j++) begin
                        shape_ok = shape_ok && pos_letter[j];
                    end
                    is_match = is_match || shape_ok;
                end
            end
        end
    end

endmodule

@@ rtl/callsign_token_finder.sv @@
// ----------------------------------------------------------------------------
// callsign_token_finder
// Scans a text one byte per item and reports its first callsign token.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle with no gaps needed. Each
// accepted item is held in an input register; from there the token logic
// (case folding, append, shape check) updates the token state, and on
// the item marked last of text the result is written to the output register.
// The output register frees the input side: new bytes keep flowing while a
// result waits, and only a second last-of-text item stalls until the first
// result is taken. After each result the token state returns to its reset
// values, ready for the next text.
module callsign_token_finder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cstf_pkg::cstf_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cstf_pkg::cstf_out_t m_item
);
    import cstf_pkg::*;

    // Input register.
    logic       in_valid_reg;
    cstf_in_t   in_item_reg;

    // Token and match state.
    tok_buf_t   tok_buf_reg,   tok_buf_next;
    tok_len_t   tok_len_reg,   tok_len_next;
    logic       match_seen_reg, match_seen_next;
    tok_buf_t   held_buf_reg,  held_buf_next;
    logic [2:0] held_len_reg,  held_len_next;

    // Result register.
    logic       out_valid_reg;
    cstf_out_t  out_item_reg,  out_item_next;

    char_info_t info;
    tok_buf_t   eff_buf;
    tok_len_t   eff_len;
    logic       is_match;
    logic       closing;
    logic       out_free;
    logic       fire;

    // Handshake: a last-of-text item needs a free result register.
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && (!in_item_reg.last_of_text || out_free);
    assign s_ready  = !in_valid_reg || fire;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    cstf_char_fold u_fold (
        .raw_byte (in_item_reg.text_byte),
        .info     (info)
    );

    // The current token with this item's character appended when it is one.
    always_comb begin
        eff_buf = tok_buf_reg;
        eff_len = tok_len_reg;
        if (info.is_alnum) begin
            if (tok_len_reg < LEN_W'(TOKEN_MAX)) begin
                eff_buf[tok_len_reg[2:0]] = info.ch;
            end
            if (tok_len_reg < LEN_W'(LEN_SAT)) begin
                eff_len = tok_len_reg + 1'b1;
            end
        end
    end

    cstf_token_check u_check (
        .tok_buf  (eff_buf),
        .tok_len  (eff_len),
        .is_match (is_match)
    );

    // A separator or the end of text closes the token.
    assign closing = !info.is_alnum || in_item_reg.last_of_text;

    // Next token, match and result values.
    always_comb begin
        tok_buf_next    = eff_buf;
        tok_len_next    = eff_len;
        match_seen_next = match_seen_reg;
        held_buf_next   = held_buf_reg;
        held_len_next   = held_len_reg;
        if (closing) begin
            tok_buf_next = '0;
            tok_len_next = '0;
            if (!match_seen_reg && is_match) begin
                match_seen_next = 1'b1;
                held_buf_next   = eff_buf;
                held_len_next   = eff_len[2:0];
            end
        end
        out_item_next.found           = match_seen_next;
        out_item_next.callsign_chars  = held_buf_next;
        out_item_next.callsign_length = held_len_next;
        // The text ends here: start the next one from reset.
        if (in_item_reg.last_of_text) begin
            match_seen_next = 1'b0;
            held_buf_next   = '0;
            held_len_next   = '0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    // Token state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_buf_reg    <= '0;
            tok_len_reg    <= '0;
            match_seen_reg <= 1'b0;
            held_buf_reg   <= '0;
            held_len_reg   <= '0;
        end else if (fire) begin
            tok_buf_reg    <= tok_buf_next;
            tok_len_reg    <= tok_len_next;
            match_seen_reg <= match_seen_next;
            held_buf_reg   <= held_buf_next;
            held_len_reg   <= held_len_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_item_reg.last_of_text) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire && in_item_reg.last_of_text) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

@@ bench/callsign_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// callsign_checker
// Watches both channels of the callsign token finder and checks its results.
// ----------------------------------------------------------------------------
// Every accepted input item is run through a cycle-free copy of the token
// logic kept here. Each last-of-text item queues one expected result. Every
// accepted result is compared field by field with the oldest expected one.
// The failure count and the number of results still owed go to the top.
// ----------------------------------------------------------------------------
module callsign_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  cstf_pkg::cstf_in_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  cstf_pkg::cstf_out_t m_item,
    output int                  fail_count,
    output int                  pending_results,
    output int                  results_checked,
    output int                  callsigns_found
);
    import cstf_pkg::*;

    // Predicted token state.
    char_t       tok_chars [TOKEN_MAX];
    tok_len_t    tok_len;
    logic        match_held;
    logic [55:0] held_chars;
    logic [2:0]  held_len;

    cstf_out_t   expected_results [$];

    function automatic logic is_upper(input char_t c);
        return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
    endfunction

    function automatic logic is_num(input char_t c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Close the current token: latch it if it is the first callsign, then
    // empty the token buffer.
    task automatic end_token();
        int          n;
        int          k;
        int          lead;
        int          i;
        logic [55:0] word;
        n    = tok_len;
        k    = 0;
        word = '0;
        if (!match_held && n >= 3 && n <= TOKEN_MAX) begin
            while (k < n && is_upper(tok_chars[n-1-k])) begin
                k++;
            end
            if (k >= 1 && k <= 3 && k < n && is_num(tok_chars[n-1-k])) begin
                lead = n - 1 - k;
                if (lead >= 1 && lead <= 3) begin
                    for (i = 0; i < n; i++) begin
                        word[8*(6-i) +: 8] = tok_chars[i];
                    end
                    held_chars = word;
                    held_len   = n[2:0];
                    match_held = 1'b1;
                end
            end
        end
        tok_len = '0;
        for (i = 0; i < TOKEN_MAX; i++) begin
            tok_chars[i] = '0;
        end
    endtask

    initial begin
        fail_count      = 0;
        pending_results = 0;
        results_checked = 0;
        callsigns_found = 0;
    end

    always @(posedge aclk) begin
        cstf_out_t want;
        char_t     c;
        if (!aresetn) begin
            end_token();
            match_held = 1'b0;
            held_chars = '0;
            held_len   = '0;
            expected_results.delete();
        end else begin
            // Compare an accepted result with the oldest expected one.
            if (m_valid && m_ready) begin
                results_checked++;
                if (m_item.found) begin
                    callsigns_found++;
                end
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with none expected, got %h", $time, m_item);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.found !== want.found) begin
                        $display("%0t: found expected %0b, got %0b",
                                 $time, want.found, m_item.found);
                        fail_count++;
                    end
                    if (m_item.callsign_chars !== want.callsign_chars) begin
                        $display("%0t: callsign_chars expected %h, got %h",
                                 $time, want.callsign_chars, m_item.callsign_chars);
                        fail_count++;
                    end
                    if (m_item.callsign_length !== want.callsign_length) begin
                        $display("%0t: callsign_length expected %0d, got %0d",
                                 $time, want.callsign_length, m_item.callsign_length);
                        fail_count++;
                    end
                end
            end

            // Run an accepted input item through the predicted token logic.
            if (s_valid && s_ready) begin
                c = s_item.text_byte;
                if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
                    c = c - CASE_OFFSET;
                end
                if (is_upper(c) || is_num(c)) begin
                    if (tok_len < TOKEN_MAX) begin
                        tok_chars[tok_len] = c;
                    end
                    if (tok_len < LEN_SAT) begin
                        tok_len = tok_len + 1'b1;
                    end
                end else begin
                    end_token();
                end

                // The last byte closes the text and starts the next one clean.
                if (s_item.last_of_text) begin
                    end_token();
                    want.found           = match_held;
                    want.callsign_chars  = held_chars;
                    want.callsign_length = held_len;
                    expected_results.insert(expected_results.size(), want);
                    match_held = 1'b0;
                    held_chars = '0;
                    held_len   = '0;
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

@@ bench/tb_callsign_token_finder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_callsign_token_finder
// Stimulus and verdict for the callsign token finder.
// ----------------------------------------------------------------------------
// A short directed set of texts covers case folding, bytes at both ends of
// the range, overlong tokens, the longest callsign and later matches. Random
// texts follow, mostly built from callsign-shaped tokens, near misses and
// plain alphanumeric runs between random separators, with some raw noise.
// Both sides idle in random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_callsign_token_finder;
    import cstf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_FROM   = 680;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    cstf_in_t  s_item;
    logic      m_valid;
    logic      m_ready;
    cstf_out_t m_item;

    int        fail_count;
    int        pending_results;
    int        results_checked;
    int        callsigns_found;

    int        items_sent;
    int        texts_sent;
    int        cycles;
    logic      send_gaps;
    logic      recv_stalls;
    logic [7:0] text_q [$];

    callsign_token_finder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    callsign_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .callsigns_found (callsigns_found)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Add one byte at the end of the text being built.
    function automatic void append_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    // Character generators for building texts.
    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = CHAR_UPPER_A + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) begin
            c = c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(0, 2) == 0 ? rand_digit() : rand_letter();
    endfunction

    function automatic logic [7:0] rand_separator();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(0, CHAR_ZERO - 1));
            1: return 8'($urandom_range(CHAR_NINE + 1, CHAR_UPPER_A - 1));
            2: return 8'($urandom_range(CHAR_UPPER_Z + 1, CHAR_LOWER_A - 1));
            3: return 8'($urandom_range(CHAR_LOWER_Z + 1, 255));
            default: return 8'h20;
        endcase
    endfunction

    // Append a token shaped as lead characters, one digit and a letter tail.
    task automatic add_shaped_token(input int lead, input int tail);
        int i;
        for (i = 0; i < lead; i++) begin
            append_byte(rand_alnum());
        end
        append_byte(rand_digit());
        for (i = 0; i < tail; i++) begin
            append_byte(rand_letter());
        end
    endtask

    task automatic add_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            append_byte(s[i]);
        end
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic [7:0] b, input logic last);
        cstf_in_t it;
        it.text_byte    = b;
        it.last_of_text = last;
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        items_sent++;
    endtask

    // Send the built text, marking its final byte, and empty the buffer.
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            send_item(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
        texts_sent++;
    endtask

    // Stop offering items and wait until every expected result has come.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
        @(posedge aclk);
    endtask

    // Build one random text: mostly token sequences, some raw noise.
    task automatic build_random_text();
        int n_tok;
        int i;
        int n;
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++) begin
                append_byte(8'($urandom_range(0, 255)));
            end
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                append_byte(rand_separator());
            end
            n_tok = $urandom_range(1, 4);
            for (i = 0; i < n_tok; i++) begin
                if (i > 0) begin
                    repeat ($urandom_range(1, 2)) append_byte(rand_separator());
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        add_shaped_token($urandom_range(1, 3), $urandom_range(1, 3));
                    6:
                        add_shaped_token($urandom_range(0, 1) ? 0 : 4, $urandom_range(1, 3));
                    7:
                        add_shaped_token($urandom_range(1, 3), $urandom_range(0, 1) ? 0 : 4);
                    default: begin
                        n = $urandom_range(1, 10);
                        repeat (n) append_byte(rand_alnum());
                    end
                endcase
            end
            if ($urandom_range(0, 1)) begin
                append_byte(rand_separator());
            end
        end
    endtask

    // Result side: random stall bursts while stalls are enabled.
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (recv_stalls && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // Run limit.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        items_sent  = 0;
        texts_sent  = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Lower-case callsign ending on the last byte.
        add_string("9a1z");
        send_text();
        // Both ends of the byte range, no token at all.
        append_byte(8'hFF);
        append_byte(8'h00);
        send_text();
        // Overlong token, a high separator, the longest callsign, and a
        // later match that must be ignored.
        add_string("12345678");
        append_byte(8'h80);
        add_string("abc9xyz/K2x");
        send_text();

        // Let everything drain before the random part.
        wait_drained();

        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= QUIET_FROM) begin
                send_gaps   = 1'b0;
                recv_stalls = 1'b0;
            end else begin
                send_gaps   = $urandom_range(0, 3) != 0;
                recv_stalls = $urandom_range(0, 3) != 0;
            end
            build_random_text();
            send_text();
            if (texts_sent % 25 == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes in %0d texts; %0d results checked, %0d with a callsign.",
                 items_sent, texts_sent, results_checked, callsigns_found);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
